// ===== hw/rtl/indexed_linked_list_engine_macros.svh =====
// Assertion helpers used by the RTL engine.
`ifndef INDEXED_LINKED_LIST_ENGINE_MACROS_SVH
`define INDEXED_LINKED_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, checked on i_clk, off during reset.
`define LIL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on i_clk, off during reset.
`define LIL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/lil_pkg.sv =====
package lil_pkg;

    localparam int POS_W = 8;
    localparam int VAL_W = 32;
    localparam int CNT_W = 8;

    localparam logic signed [VAL_W-1:0] INT_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    // Per-cycle strobes for one memory port pair.
    typedef struct packed {
        logic rd;
        logic wr;
    } t_mem_ctl;

endpackage

// ===== hw/rtl/lil_link_store.sv =====
module lil_link_store import lil_pkg::*; #(
    parameter int SLOTS = 128,
    parameter int IW    = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_mem_ctl      i_ctl,
    input  logic [IW-1:0] i_rd_addr,
    input  logic [IW-1:0] i_wr_addr,
    input  logic [IW-1:0] i_wr_data,
    output logic [IW-1:0] o_rd_data
);

    localparam int AW = $clog2(SLOTS);
    localparam logic [IW-1:0] NULL_SLOT = IW'(SLOTS);

    logic [IW-1:0] mem [SLOTS];
    logic [IW-1:0] r_q;
    logic [IW-1:0] r_addr;
    logic          r_null;
    logic          r_fresh;
    // Slots at or above the fill mark were never written and still hold
    // their reset link (slot + 1).
    logic [IW-1:0] r_fill;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr && i_wr_addr < NULL_SLOT) begin
            mem[i_wr_addr[AW-1:0]] <= i_wr_data;
        end
        if (i_ctl.rd) begin
            r_q     <= mem[i_rd_addr[AW-1:0]];
            r_addr  <= i_rd_addr;
            r_null  <= (i_rd_addr >= NULL_SLOT);
            r_fresh <= (i_rd_addr >= r_fill);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_ctl.wr && i_wr_addr == r_fill && r_fill < NULL_SLOT) begin
            r_fill <= r_fill + IW'(1);
        end
    end

    always_comb begin
        if (r_null) begin
            o_rd_data = NULL_SLOT;
        end else if (r_fresh) begin
            o_rd_data = r_addr + IW'(1);
        end else if (r_q >= NULL_SLOT) begin
            o_rd_data = NULL_SLOT;
        end else begin
            o_rd_data = r_q;
        end
    end

endmodule

// ===== hw/rtl/lil_value_store.sv =====
module lil_value_store import lil_pkg::*; #(
    parameter int SLOTS = 128,
    parameter int IW    = 8
) (
    input  logic                    i_clk,
    input  t_mem_ctl                i_ctl,
    input  logic [IW-1:0]           i_rd_addr,
    input  logic [IW-1:0]           i_wr_addr,
    input  logic signed [VAL_W-1:0] i_wr_data,
    output logic signed [VAL_W-1:0] o_rd_data
);

    localparam int AW = $clog2(SLOTS);

    logic signed [VAL_W-1:0] mem [SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr && i_wr_addr < IW'(SLOTS)) begin
            mem[i_wr_addr[AW-1:0]] <= i_wr_data;
        end
        if (i_ctl.rd) begin
            o_rd_data <= mem[i_rd_addr[AW-1:0]];
        end
    end

endmodule

// ===== hw/rtl/indexed_linked_list_engine.sv =====
// A rejected request skips the walk, as does a head or empty-list change;
// other requests walk the links to their position before the result strobe.
// Throughput: one request at a time; busy drops the cycle after the strobe.
// Reset (synchronous, active low): empty list, no clearing pass needed.
`include "indexed_linked_list_engine_macros.svh"

// Singly linked list held in two slot memories.
//
//   link store  : next-slot number of each slot; SLOTS means null.
//   value store : 32-bit value of each slot.
//
// Free slots form a chain starting at r_free. The link store keeps a fill
// mark: every slot at or above it still holds its reset link, so the reset
// chain 0 -> 1 -> ... -> null exists without sweeping the memory.
//
// Request flow (one-hot sequencer):
//   CHECK    range / full checks, start allocation or walk
//   ALLOC    pop the free chain, write the value, maybe link to head
//   WALK     follow links, one read per cycle; read data feeds the
//            next read address directly
//   ARRIVE   act on the reached slot
//   then a short tail of link reads/writes per command, and DONE.
// Each memory access is ordered by the sequencer so a read never meets a
// write to the same slot in the same cycle: no forwarding path is needed.
// The receiver cannot stall: o_done is high for exactly one cycle.
module indexed_linked_list_engine import lil_pkg::*; #(
    parameter int SLOTS = 128
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              i_cmd,
    input  logic [POS_W-1:0]        i_position,
    input  logic signed [VAL_W-1:0] i_item_value,
    output logic                    o_done,
    output logic [1:0]              o_status,
    output logic signed [VAL_W-1:0] o_read_value,
    output logic [CNT_W-1:0]        o_entry_count
);

    // Slot numbers carry one extra code for null; count shares the width.
    localparam int IW = $clog2(SLOTS + 1);
    localparam int PW = (IW > POS_W) ? IW : POS_W;
    localparam int OW = (PW > CNT_W) ? PW : CNT_W;
    localparam logic [IW-1:0] NULL_SLOT = IW'(SLOTS);

    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_CHECK    = 13'b0000000000010,
        S_ALLOC    = 13'b0000000000100,
        S_WALK     = 13'b0000000001000,
        S_ARRIVE   = 13'b0000000010000,
        S_INS_LINK = 13'b0000000100000,
        S_INS_FIX  = 13'b0000001000000,
        S_RM_HEAD  = 13'b0000010000000,
        S_RM_NEXT  = 13'b0000100000000,
        S_RM_FIX   = 13'b0001000000000,
        S_RM_FREE  = 13'b0010000000000,
        S_RD_VAL   = 13'b0100000000000,
        S_DONE     = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;

    // request
    t_cmd                    r_cmd;
    logic [POS_W-1:0]        r_pos;
    logic signed [VAL_W-1:0] r_val;

    // list state
    logic [IW-1:0] r_head,  n_head;
    logic [IW-1:0] r_free,  n_free;
    logic [IW-1:0] r_count, n_count;

    // working registers
    logic [IW-1:0]           r_cur,    n_cur;
    logic [IW-1:0]           r_slot,   n_slot;
    logic [IW-1:0]           r_prev,   n_prev;
    logic [IW-1:0]           r_victim, n_victim;
    logic [PW-1:0]           r_steps,  n_steps;
    logic                    r_pend,   n_pend;
    t_status                 r_status, n_status;
    logic signed [VAL_W-1:0] r_rd,     n_rd;

    // memory ports
    t_mem_ctl                lk_ctl;
    logic [IW-1:0]           lk_rd_addr;
    logic [IW-1:0]           lk_wr_addr;
    logic [IW-1:0]           lk_wr_data;
    logic [IW-1:0]           lk_q;
    t_mem_ctl                vs_ctl;
    logic [IW-1:0]           vs_rd_addr;
    logic signed [VAL_W-1:0] vs_q;

    logic [IW-1:0] walk_slot;
    logic [PW-1:0] pos_x;
    logic [PW-1:0] cnt_x;
    logic [OW-1:0] cnt_out;
    logic          accept;

    assign accept    = start && !busy;
    assign busy      = (r_state != S_IDLE);
    // while a link read is in flight the walk position is its result
    assign walk_slot = r_pend ? lk_q : r_cur;
    assign pos_x     = PW'(r_pos);
    assign cnt_x     = PW'(r_count);
    assign cnt_out   = OW'(r_count);

    lil_link_store #(
        .SLOTS (SLOTS),
        .IW    (IW)
    ) u_link (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (lk_ctl),
        .i_rd_addr (lk_rd_addr),
        .i_wr_addr (lk_wr_addr),
        .i_wr_data (lk_wr_data),
        .o_rd_data (lk_q)
    );

    lil_value_store #(
        .SLOTS (SLOTS),
        .IW    (IW)
    ) u_value (
        .i_clk     (i_clk),
        .i_ctl     (vs_ctl),
        .i_rd_addr (vs_rd_addr),
        .i_wr_addr (r_slot),
        .i_wr_data (r_val),
        .o_rd_data (vs_q)
    );

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_free     = r_free;
        n_count    = r_count;
        n_cur      = r_cur;
        n_slot     = r_slot;
        n_prev     = r_prev;
        n_victim   = r_victim;
        n_steps    = r_steps;
        n_pend     = r_pend;
        n_status   = r_status;
        n_rd       = r_rd;
        lk_ctl     = '0;
        lk_rd_addr = r_cur;
        lk_wr_addr = r_slot;
        lk_wr_data = NULL_SLOT;
        vs_ctl     = '0;
        vs_rd_addr = r_cur;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_CHECK;
                end
            end

            S_CHECK: begin
                n_status = ST_DONE;
                n_rd     = '0;
                n_cur    = r_head;
                n_pend   = 1'b0;
                n_slot   = r_free;
                n_state  = S_DONE;
                case (r_cmd)
                    CMD_APPEND, CMD_INSERT: begin
                        if (r_cmd == CMD_INSERT && pos_x > cnt_x) begin
                            n_status = ST_BAD_POS;
                        end else if (r_free >= NULL_SLOT) begin
                            n_status = ST_FULL;
                        end else begin
                            // next free slot comes back in ALLOC
                            lk_ctl.rd  = 1'b1;
                            lk_rd_addr = r_free;
                            n_state    = S_ALLOC;
                        end
                    end
                    CMD_REMOVE: begin
                        if (pos_x >= cnt_x || r_head >= NULL_SLOT) begin
                            n_status = ST_BAD_POS;
                        end else if (pos_x == '0) begin
                            n_victim   = r_head;
                            lk_ctl.rd  = 1'b1;
                            lk_rd_addr = r_head;
                            n_state    = S_RM_HEAD;
                        end else begin
                            n_steps = pos_x - PW'(1);
                            n_state = S_WALK;
                        end
                    end
                    CMD_READ: begin
                        if (pos_x >= cnt_x) begin
                            n_status = ST_BAD_POS;
                            n_rd     = INT_MIN;
                        end else begin
                            n_steps = pos_x;
                            n_state = S_WALK;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end

            S_ALLOC: begin
                n_free    = lk_q;
                vs_ctl.wr = 1'b1;
                if (r_cmd == CMD_APPEND) begin
                    lk_ctl.wr  = 1'b1;
                    lk_wr_addr = r_slot;
                    lk_wr_data = NULL_SLOT;
                    if (r_count == '0 || r_head >= NULL_SLOT) begin
                        n_head  = r_slot;
                        n_count = r_count + IW'(1);
                        n_state = S_DONE;
                    end else begin
                        n_steps = cnt_x - PW'(1);
                        n_state = S_WALK;
                    end
                end else if (pos_x == '0) begin
                    lk_ctl.wr  = 1'b1;
                    lk_wr_addr = r_slot;
                    lk_wr_data = r_head;
                    n_head     = r_slot;
                    n_count    = r_count + IW'(1);
                    n_state    = S_DONE;
                end else begin
                    n_steps = pos_x - PW'(1);
                    n_state = S_WALK;
                end
            end

            S_WALK: begin
                n_cur = walk_slot;
                if (r_steps == '0 || walk_slot >= NULL_SLOT) begin
                    n_pend  = 1'b0;
                    n_state = S_ARRIVE;
                end else begin
                    lk_ctl.rd  = 1'b1;
                    lk_rd_addr = walk_slot;
                    n_steps    = r_steps - PW'(1);
                    n_pend     = 1'b1;
                end
            end

            S_ARRIVE: begin
                n_prev = r_cur;
                case (r_cmd)
                    CMD_APPEND: begin
                        lk_ctl.wr  = 1'b1;
                        lk_wr_addr = r_cur;
                        lk_wr_data = r_slot;
                        n_count    = r_count + IW'(1);
                        n_state    = S_DONE;
                    end
                    CMD_INSERT: begin
                        lk_ctl.rd  = 1'b1;
                        lk_rd_addr = r_cur;
                        n_state    = S_INS_LINK;
                    end
                    CMD_REMOVE: begin
                        lk_ctl.rd  = 1'b1;
                        lk_rd_addr = r_cur;
                        n_state    = S_RM_NEXT;
                    end
                    CMD_READ: begin
                        vs_ctl.rd  = 1'b1;
                        vs_rd_addr = r_cur;
                        n_state    = S_RD_VAL;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end

            S_INS_LINK: begin
                // new slot takes over the successor of prev
                lk_ctl.wr  = 1'b1;
                lk_wr_addr = r_slot;
                lk_wr_data = lk_q;
                n_state    = S_INS_FIX;
            end

            S_INS_FIX: begin
                lk_ctl.wr  = 1'b1;
                lk_wr_addr = r_prev;
                lk_wr_data = r_slot;
                n_count    = r_count + IW'(1);
                n_state    = S_DONE;
            end

            S_RM_HEAD: begin
                n_head  = lk_q;
                n_state = S_RM_FREE;
            end

            S_RM_NEXT: begin
                n_victim   = lk_q;
                lk_ctl.rd  = 1'b1;
                lk_rd_addr = lk_q;
                n_state    = S_RM_FIX;
            end

            S_RM_FIX: begin
                // bypass the victim
                lk_ctl.wr  = 1'b1;
                lk_wr_addr = r_prev;
                lk_wr_data = lk_q;
                n_state    = S_RM_FREE;
            end

            S_RM_FREE: begin
                if (r_victim < NULL_SLOT) begin
                    lk_ctl.wr  = 1'b1;
                    lk_wr_addr = r_victim;
                    lk_wr_data = r_free;
                    n_free     = r_victim;
                end
                n_count = r_count - IW'(1);
                n_state = S_DONE;
            end

            S_RD_VAL: begin
                n_rd    = (r_cur < NULL_SLOT) ? vs_q : '0;
                n_state = S_DONE;
            end

            S_DONE: begin
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= NULL_SLOT;
            r_free  <= '0;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_free  <= n_free;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= t_cmd'(i_cmd);
            r_pos <= i_position;
            r_val <= i_item_value;
        end
        r_cur    <= n_cur;
        r_slot   <= n_slot;
        r_prev   <= n_prev;
        r_victim <= n_victim;
        r_steps  <= n_steps;
        r_status <= n_status;
        r_rd     <= n_rd;
    end

    assign o_done        = (r_state == S_DONE);
    assign o_status      = r_status;
    assign o_read_value  = r_rd;
    assign o_entry_count = cnt_out[CNT_W-1:0];

    `LIL_ASSERT_NEXT(a_done_pulse, o_done, !o_done && !busy, "result strobe longer than one cycle")
    `LIL_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted request did not raise busy")
    `LIL_ASSERT_NOW(a_full_count, r_state == S_IDLE, (r_free >= NULL_SLOT) == (r_count == NULL_SLOT), "free chain and entry count disagree")
    `LIL_ASSERT_NOW(a_empty_head, r_state == S_IDLE, (r_head >= NULL_SLOT) == (r_count == '0), "head and entry count disagree")
    `LIL_ASSERT_NOW(a_bad_read, o_done && r_cmd == CMD_READ && r_status == ST_BAD_POS, o_read_value == INT_MIN, "bad read position without marker value")

endmodule

// ===== tb/sv/lil_result_checker.sv =====
// Watches the request and result channels of the linked list engine,
// keeps its own copy of the list and checks every result in order.
module lil_result_checker import lil_pkg::*; #(
    parameter int SLOTS = 128
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic                    i_busy,
    input  logic [1:0]              i_cmd,
    input  logic [POS_W-1:0]        i_position,
    input  logic signed [VAL_W-1:0] i_item_value,
    input  logic                    i_done,
    input  logic [1:0]              i_status,
    input  logic signed [VAL_W-1:0] i_read_value,
    input  logic [CNT_W-1:0]        i_entry_count,
    output int                      o_fail_count,
    output int                      o_pending,
    output logic [CNT_W-1:0]        o_entries,
    output int                      o_requests,
    output int                      o_full_replies,
    output int                      o_bad_pos_replies,
    output int                      o_peak_entries
);

    localparam int SLOT_W = $clog2(SLOTS + 1);
    localparam int IDX_W  = $clog2(SLOTS);
    localparam logic [SLOT_W-1:0] NULL_SLOT = SLOTS[SLOT_W-1:0];

    typedef struct packed {
        t_status                 status;
        logic signed [VAL_W-1:0] read_value;
        logic [CNT_W-1:0]        entry_count;
    } t_list_result;

    logic [SLOT_W-1:0]       next_slot [SLOTS];
    logic signed [VAL_W-1:0] slot_value [SLOTS];
    logic [SLOT_W-1:0]       head;
    logic [SLOT_W-1:0]       free_head;
    logic [CNT_W-1:0]        entries;

    t_list_result pending_replies [$];
    int fails;
    int requests;
    int full_replies;
    int bad_pos_replies;
    int peak;

    // Slot reached after following steps links from the head.
    function automatic logic [SLOT_W-1:0] walk_from_head(input int steps);
        logic [SLOT_W-1:0] s;
        s = head;
        for (int i = 0; i < steps && s < NULL_SLOT; i++)
            s = next_slot[s[IDX_W-1:0]];
        return s;
    endfunction

    // Applies one request to the shadow list and returns its result.
    function automatic t_list_result apply_list_request(input t_cmd cmd,
                                                        input logic [POS_W-1:0] pos,
                                                        input logic signed [VAL_W-1:0] val);
        t_list_result r;
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] prev;
        logic [SLOT_W-1:0] victim;
        r.status     = ST_DONE;
        r.read_value = '0;
        case (cmd)
            CMD_APPEND: begin
                if (free_head >= NULL_SLOT) begin
                    r.status = ST_FULL;
                end else begin
                    slot                        = free_head;
                    free_head                   = next_slot[slot[IDX_W-1:0]];
                    slot_value[slot[IDX_W-1:0]] = val;
                    next_slot[slot[IDX_W-1:0]]  = NULL_SLOT;
                    if (entries == 0) begin
                        head = slot;
                    end else begin
                        prev                       = walk_from_head(entries - 1);
                        next_slot[prev[IDX_W-1:0]] = slot;
                    end
                    entries++;
                end
            end
            CMD_INSERT: begin
                // position check wins over the full check
                if (pos > entries) begin
                    r.status = ST_BAD_POS;
                end else if (free_head >= NULL_SLOT) begin
                    r.status = ST_FULL;
                end else begin
                    slot                        = free_head;
                    free_head                   = next_slot[slot[IDX_W-1:0]];
                    slot_value[slot[IDX_W-1:0]] = val;
                    if (pos == 0) begin
                        next_slot[slot[IDX_W-1:0]] = head;
                        head                       = slot;
                    end else begin
                        prev                       = walk_from_head(pos - 1);
                        next_slot[slot[IDX_W-1:0]] = next_slot[prev[IDX_W-1:0]];
                        next_slot[prev[IDX_W-1:0]] = slot;
                    end
                    entries++;
                end
            end
            CMD_REMOVE: begin
                if (pos >= entries) begin
                    r.status = ST_BAD_POS;
                end else begin
                    if (pos == 0) begin
                        victim = head;
                        head   = next_slot[victim[IDX_W-1:0]];
                    end else begin
                        prev                       = walk_from_head(pos - 1);
                        victim                     = next_slot[prev[IDX_W-1:0]];
                        next_slot[prev[IDX_W-1:0]] = next_slot[victim[IDX_W-1:0]];
                    end
                    next_slot[victim[IDX_W-1:0]] = free_head;
                    free_head                    = victim;
                    entries--;
                end
            end
            default: begin
                if (pos >= entries) begin
                    r.status     = ST_BAD_POS;
                    r.read_value = INT_MIN;
                end else begin
                    slot         = walk_from_head(int'(pos));
                    r.read_value = slot_value[slot[IDX_W-1:0]];
                end
            end
        endcase
        r.entry_count = entries;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_list_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                next_slot[i]  = SLOT_W'(i + 1);
                slot_value[i] = '0;
            end
            head      = NULL_SLOT;
            free_head = '0;
            entries   = '0;
            pending_replies.delete();
            fails           = 0;
            requests        = 0;
            full_replies    = 0;
            bad_pos_replies = 0;
            peak            = 0;
        end else begin
            if (i_done) begin
                if (pending_replies.size() == 0) begin
                    $error("result with no request outstanding: status %0d value %0d count %0d",
                           i_status, i_read_value, i_entry_count);
                    fails++;
                end else begin
                    want = pending_replies.pop_front();
                    if (i_status !== want.status) begin
                        $error("status mismatch: expected %0d, got %0d", want.status, i_status);
                        fails++;
                    end
                    if (i_read_value !== want.read_value) begin
                        $error("read_value mismatch: expected %0d, got %0d",
                               want.read_value, i_read_value);
                        fails++;
                    end
                    if (i_entry_count !== want.entry_count) begin
                        $error("entry_count mismatch: expected %0d, got %0d",
                               want.entry_count, i_entry_count);
                        fails++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                want = apply_list_request(t_cmd'(i_cmd), i_position, i_item_value);
                pending_replies.push_back(want);
                requests++;
                if (want.status == ST_FULL)
                    full_replies++;
                if (want.status == ST_BAD_POS)
                    bad_pos_replies++;
                if (int'(entries) > peak)
                    peak = int'(entries);
            end
        end
        // published with NBAs so the stimulus side sees a stable view
        o_fail_count      <= fails;
        o_pending         <= pending_replies.size();
        o_entries         <= entries;
        o_requests        <= requests;
        o_full_replies    <= full_replies;
        o_bad_pos_replies <= bad_pos_replies;
        o_peak_entries    <= peak;
    end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the linked list engine bench: clock, reset, request stimulus,
// watchdog and verdict. All checking lives in lil_result_checker.
module testbench import lil_pkg::*; ();

    localparam int SLOTS          = 128;
    localparam int PHASE_REQS     = 120;   // random requests per phase
    localparam int WATCHDOG_LIMIT = 2000;  // well above the worst walk over a full list

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic [1:0]              i_cmd;
    logic [POS_W-1:0]        i_position;
    logic signed [VAL_W-1:0] i_item_value;
    logic                    o_done;
    logic [1:0]              o_status;
    logic signed [VAL_W-1:0] o_read_value;
    logic [CNT_W-1:0]        o_entry_count;

    int               fail_count;
    int               pending;
    logic [CNT_W-1:0] entries;
    int               requests;
    int               full_replies;
    int               bad_pos_replies;
    int               peak_entries;
    int               quiet_cycles;

    indexed_linked_list_engine #(.SLOTS(SLOTS)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .i_position   (i_position),
        .i_item_value (i_item_value),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_read_value (o_read_value),
        .o_entry_count(o_entry_count)
    );

    lil_result_checker #(.SLOTS(SLOTS)) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_cmd            (i_cmd),
        .i_position       (i_position),
        .i_item_value     (i_item_value),
        .i_done           (o_done),
        .i_status         (o_status),
        .i_read_value     (o_read_value),
        .i_entry_count    (o_entry_count),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_entries        (entries),
        .o_requests       (requests),
        .o_full_replies   (full_replies),
        .o_bad_pos_replies(bad_pos_replies),
        .o_peak_entries   (peak_entries)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog: counts cycles in which neither a request nor a result moves.
    // Longest legal quiet stretch is a sender gap plus one full-length walk.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Drives one request and holds it until the edge that accepts it.
    // start is left high: the caller lowers it only when it goes idle,
    // so back-to-back requests never see a low/high pair in one step.
    task automatic issue_request(input t_cmd cmd, input logic [POS_W-1:0] pos,
                                 input logic signed [VAL_W-1:0] val);
        start        <= 1'b1;
        i_cmd        <= cmd;
        i_position   <= pos;
        i_item_value <= val;
        do @(posedge i_clk); while (busy);
    endtask

    // Per-phase knobs. Cut points split a 0..99 roll into
    // append / insert / remove / read.
    // phase 0: grow, no gaps; phase 1: grow into full store, heavy gaps;
    // phase 2: drain, light gaps; phase 3: even mix, no gaps.
    int idle_pct   [4] = '{0, 59, 8, 0};
    int append_cut [4] = '{40, 40, 10, 25};
    int insert_cut [4] = '{80, 80, 20, 50};
    int remove_cut [4] = '{90, 90, 80, 75};

    initial begin
        t_cmd                    cmd;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] val;
        int                      roll;

        // every input known from time zero; reset held low before the first request
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_cmd        <= CMD_APPEND;
        i_position   <= '0;
        i_item_value <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed: empty list, extremes, head/middle/tail cases ---
        issue_request(CMD_READ,   8'd0,   32'sd5);          // read on empty list
        issue_request(CMD_REMOVE, 8'd0,   32'sd0);          // remove on empty list
        issue_request(CMD_INSERT, 8'd1,   32'sd7);          // insert past end of empty list
        issue_request(CMD_INSERT, 8'd0,   INT_MIN);         // insert into empty list
        issue_request(CMD_APPEND, 8'd0,   32'sh7FFF_FFFF);
        issue_request(CMD_APPEND, 8'd200, -32'sd1);         // append ignores position
        issue_request(CMD_INSERT, 8'd3,   32'sd0);          // insert at tail (pos == count)
        issue_request(CMD_INSERT, 8'd2,   32'sh5A5A_A5A5);  // insert in the middle
        issue_request(CMD_INSERT, 8'd6,   32'sd1);          // one past the end
        issue_request(CMD_READ,   8'd0,   32'sd0);
        issue_request(CMD_READ,   8'd4,   32'sd0);          // last entry
        issue_request(CMD_READ,   8'd5,   32'sd0);          // pos == count
        issue_request(CMD_READ,   8'hFF,  32'sd0);
        issue_request(CMD_REMOVE, 8'hFF,  32'sd0);
        issue_request(CMD_INSERT, 8'hFF,  32'sd0);
        issue_request(CMD_REMOVE, 8'd0,   32'sd0);          // head
        issue_request(CMD_REMOVE, 8'd3,   32'sd0);          // tail
        issue_request(CMD_REMOVE, 8'd1,   32'sd0);          // middle
        issue_request(CMD_APPEND, 8'hFF,  32'sh1234_5678);  // reuses freed slots
        issue_request(CMD_INSERT, 8'd0,   32'shFFFF_0000);  // new head
        issue_request(CMD_READ,   8'd1,   32'sd0);
        issue_request(CMD_READ,   8'd3,   32'sd0);

        // --- random phases ---
        for (int phase = 0; phase < 4; phase++) begin
            for (int n = 0; n < PHASE_REQS; n++) begin
                roll = $urandom_range(99);
                cmd  = roll < append_cut[phase] ? CMD_APPEND :
                       roll < insert_cut[phase] ? CMD_INSERT :
                       roll < remove_cut[phase] ? CMD_REMOVE : CMD_READ;
                // mostly positions around the live list, sometimes anything
                if ($urandom_range(99) < 85)
                    pos = POS_W'($urandom_range(entries));
                else
                    pos = POS_W'($urandom_range(255));
                case ($urandom_range(9))
                    0:       val = INT_MIN;
                    1:       val = 32'sh7FFF_FFFF;
                    2:       val = -32'sd1;
                    3:       val = 32'sd0;
                    default: val = $urandom();
                endcase
                issue_request(cmd, pos, val);
                if ($urandom_range(99) < idle_pct[phase]) begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 24)) @(posedge i_clk);
                end
            end
        end

        // drain: one edge so the last request shows up as pending, then
        // wait for every result, then a walk's worth of extra cycles
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SLOTS + 8) @(posedge i_clk);

        $display("run covered %0d requests: %0d store-full and %0d bad-position replies,",
                 requests, full_replies, bad_pos_replies);
        $display("list length peaked at %0d of %0d slots", peak_entries, SLOTS);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("status: fail");
        end
        $finish;
    end

endmodule
